@@ design/dqsb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dqsb_pkg;

  localparam int unsigned DEPTH      = 32;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned PTR_W      = $clog2(DEPTH + 1);
  localparam int unsigned IO_W       = 32;

  localparam logic [PTR_W-1:0] PTR_TOP  = PTR_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_ZERO = '0;

  localparam logic ACT_ENQ    = 1'b0;
  localparam logic ACT_DEQ    = 1'b1;
  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_OVF = 2'd1,
    STATUS_UNF = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic    valid;
    logic    rd_ok;
    status_e status;
    logic    left_empty;
    logic    right_empty;
    logic    full;
  } res_t;

  function automatic logic [DATA_WIDTH-1:0] to_word(input logic [IO_W-1:0] v);
    logic [63:0] v64;
    v64 = 64'(v);
    return v64[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [IO_W-1:0] from_word(input logic [DATA_WIDTH-1:0] w);
    logic [63:0] w64;
    w64 = 64'(w);
    return w64[IO_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/dqsb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dqsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire                      re_i,
  input  wire [$clog2(DEPTH)-1:0]  addr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/dqsb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dqsb_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          action_i,
  input  wire                          side_i,
  input  wire [dqsb_pkg::IO_W-1:0]     value_i,
  input  wire                          out_free_i,
  output dqsb_pkg::mem_req_t           mem_o,
  output dqsb_pkg::res_t               res_o
);

  // left pointers are held one above their index, so empty is zero
  logic [dqsb_pkg::PTR_W-1:0] lh_q, lh_d, lt_q, lt_d;
  logic [dqsb_pkg::PTR_W-1:0] rh_q, rh_d, rt_q, rt_d;
  logic [dqsb_pkg::PTR_W-1:0] addr_w;
  dqsb_pkg::state_e state_q, state_d;
  dqsb_pkg::res_t   pend_q, pend_d;
  logic             accept;

  assign in_ready_o = (state_q == dqsb_pkg::ST_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lh_q    <= dqsb_pkg::PTR_ZERO;
      lt_q    <= dqsb_pkg::PTR_ZERO;
      rh_q    <= dqsb_pkg::PTR_TOP;
      rt_q    <= dqsb_pkg::PTR_TOP;
      state_q <= dqsb_pkg::ST_IDLE;
    end else begin
      lh_q    <= lh_d;
      lt_q    <= lt_d;
      rh_q    <= rh_d;
      rt_q    <= rt_d;
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  always_comb begin
    lh_d        = lh_q;
    lt_d        = lt_q;
    rh_d        = rh_q;
    rt_d        = rt_q;
    state_d     = state_q;
    pend_d      = pend_q;
    addr_w      = dqsb_pkg::PTR_ZERO;
    mem_o       = '0;
    mem_o.wdata = dqsb_pkg::to_word(value_i);
    res_o       = pend_q;
    res_o.valid = 1'b0;
    unique case (state_q)
      dqsb_pkg::ST_IDLE: begin
        if (accept) begin
          pend_d.valid  = 1'b1;
          pend_d.rd_ok  = 1'b0;
          pend_d.status = dqsb_pkg::STATUS_OK;
          if (action_i == dqsb_pkg::ACT_ENQ) begin
            if (lt_q == rt_q) begin
              pend_d.status = dqsb_pkg::STATUS_OVF;
            end else if (side_i == dqsb_pkg::SIDE_RIGHT) begin
              if (rt_q == dqsb_pkg::PTR_TOP) begin
                rt_d = dqsb_pkg::PTR_TOP - 1'b1;
                rh_d = dqsb_pkg::PTR_TOP - 1'b1;
              end else begin
                rt_d = rt_q - 1'b1;
              end
              mem_o.we = 1'b1;
              addr_w   = rt_d;
            end else begin
              if (lt_q == dqsb_pkg::PTR_ZERO) begin
                lt_d = dqsb_pkg::PTR_W'(1);
                lh_d = dqsb_pkg::PTR_W'(1);
              end else begin
                lt_d = lt_q + 1'b1;
              end
              mem_o.we = 1'b1;
              addr_w   = lt_d - 1'b1;
            end
          end else if (side_i == dqsb_pkg::SIDE_RIGHT) begin
            if (rh_q == dqsb_pkg::PTR_TOP) begin
              pend_d.status = dqsb_pkg::STATUS_UNF;
            end else begin
              mem_o.re     = 1'b1;
              pend_d.rd_ok = 1'b1;
              addr_w       = rh_q;
              if (rh_q == rt_q) begin
                rh_d = dqsb_pkg::PTR_TOP;
                rt_d = dqsb_pkg::PTR_TOP;
              end else begin
                rh_d = rh_q - 1'b1;
              end
            end
          end else begin
            if (lh_q == dqsb_pkg::PTR_ZERO) begin
              pend_d.status = dqsb_pkg::STATUS_UNF;
            end else begin
              mem_o.re     = 1'b1;
              pend_d.rd_ok = 1'b1;
              addr_w       = lh_q - 1'b1;
              if (lh_q == lt_q) begin
                lh_d = dqsb_pkg::PTR_ZERO;
                lt_d = dqsb_pkg::PTR_ZERO;
              end else begin
                lh_d = lh_q + 1'b1;
              end
            end
          end
          pend_d.left_empty  = (lh_d == dqsb_pkg::PTR_ZERO);
          pend_d.right_empty = (rh_d == dqsb_pkg::PTR_TOP);
          pend_d.full        = (lt_d == rt_d);
          state_d            = dqsb_pkg::ST_READ;
        end
      end
      dqsb_pkg::ST_READ: begin
        res_o.valid = 1'b1;
        state_d     = dqsb_pkg::ST_IDLE;
      end
      default: begin
        state_d = dqsb_pkg::ST_IDLE;
      end
    endcase
    mem_o.addr = addr_w[dqsb_pkg::ADDR_W-1:0];
  end

  a_tails_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lt_q <= rt_q)
    else $error("left tail passed right tail");

  a_left_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lh_q == dqsb_pkg::PTR_ZERO) == (lt_q == dqsb_pkg::PTR_ZERO))
    else $error("left head and tail disagree on empty");

  a_right_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rh_q == dqsb_pkg::PTR_TOP) == (rt_q == dqsb_pkg::PTR_TOP))
    else $error("right head and tail disagree on empty");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_o.we && mem_o.re))
    else $error("read and write in one cycle");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> res_o.valid)
    else $error("transfer without result");

endmodule

`default_nettype wire

@@ design/dual_queue_shared_buffer_unit.sv @@
// channel | dir | tdata                | tuser
// s_axis  | in  | [31:0] value         | [0] action, [1] side
// m_axis  | out | [31:0] read_value    | [1:0] status, [2] left_empty,
//         |     |                      | [3] right_empty, [4] buffer_full
// each transfer is handled in turn: the idle state updates the pointers and issues
// the single memory access, the read state waits for the registered read data of the store
// the result sits in an output register; a new transfer is taken in the idle state once
// that register is empty or drains in the same cycle
// reset empties both queues at once; store contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module dual_queue_shared_buffer_unit (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire [dqsb_pkg::IO_W-1:0]  s_axis_tdata,  // value
  input  wire [1:0]                 s_axis_tuser,  // action, side
  output logic                      m_axis_tvalid,
  input  wire                       m_axis_tready,
  output logic [dqsb_pkg::IO_W-1:0] m_axis_tdata,  // read_value
  output logic [4:0]                m_axis_tuser   // status, left_empty, right_empty, buffer_full
);

  dqsb_pkg::mem_req_t              mem_req;
  dqsb_pkg::res_t                  res;
  logic [dqsb_pkg::DATA_WIDTH-1:0] rdata;
  logic                            tvalid_q, tvalid_d;
  logic [dqsb_pkg::IO_W-1:0]       tdata_q, tdata_d;
  logic [4:0]                      tuser_q, tuser_d;

  dqsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser[0]),
    .side_i     (s_axis_tuser[1]),
    .value_i    (s_axis_tdata),
    .out_free_i (!tvalid_q || m_axis_tready),
    .mem_o      (mem_req),
    .res_o      (res)
  );

  dqsb_ram #(
    .WIDTH (dqsb_pkg::DATA_WIDTH),
    .DEPTH (dqsb_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    tvalid_d = tvalid_q && !m_axis_tready;
    tdata_d  = tdata_q;
    tuser_d  = tuser_q;
    if (res.valid) begin
      tvalid_d = 1'b1;
      tdata_d  = res.rd_ok ? dqsb_pkg::from_word(rdata) : '0;
      tuser_d  = {res.full, res.right_empty, res.left_empty, res.status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else begin
      tvalid_q <= tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tdata_q <= tdata_d;
    tuser_q <= tuser_d;
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

endmodule

`default_nettype wire
